[sv/ptpp_pkg.sv]
package ptpp_pkg;

	localparam int QUEUE_AW = 2;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	localparam logic [7:0] HDR_PAD = 8'h00;
	localparam logic [7:0] HDR_END = 8'h01;
	localparam logic [7:0] MASK_MID = 8'hCF;
	localparam logic [7:0] MASK_LO2 = 8'hFC;
	localparam logic [7:0] MASK_LO3 = 8'hF8;
	localparam logic [7:0] HDR_EVT = 8'h42;
	localparam logic [7:0] HDR_DSRC = 8'h43;
	localparam logic [7:0] HDR_OP = 8'h48;
	localparam logic [7:0] HDR_CTX = 8'h64;
	localparam logic [7:0] HDR_TS = 8'h71;
	localparam logic [7:0] HDR_CNT = 8'h98;
	localparam logic [7:0] HDR_ADDR = 8'hB0;
	localparam logic [7:0] HDR_LONG = 8'h20;

	localparam int PC_W = 56;
	localparam int EVT_W = 19;
	localparam logic [EVT_W-1:0] EVT_MASK = 19'h70FFF;

	localparam logic [1:0] OPC_LDST = 2'd1;
	localparam logic [1:0] OPC_BR = 2'd2;
	localparam logic [1:0] SUB_GP = 2'd0;
	localparam logic [1:0] SUB_SIMD = 2'd1;
	localparam logic [1:0] SUB_OTHER = 2'd2;
	localparam logic [6:0] LDST_SIMD_CODE = 7'd2;

	typedef enum logic {
		PH_HEADER,
		PH_DATA
	} phase_t;

	typedef enum logic [2:0] {
		K_UNKNOWN,
		K_ADDR,
		K_CNT,
		K_EVT,
		K_DSRC,
		K_OP,
		K_CTX,
		K_TS
	} kind_t;

	typedef enum logic {
		CMD_DATA,
		CMD_END
	} cmd_t;

	typedef struct packed {
		cmd_t       cmd;
		kind_t      kind;
		logic [7:0] data;
		logic [2:0] pos;
		logic       last;
		logic       is_pc;
		logic [1:0] op_cls;
	} qentry_t;

endpackage

[sv/ptpp_if.sv]
interface ptpp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface ptpp_rec_if;
	logic        valid;
	logic        ready;
	logic [55:0] pc_address;
	logic        op_present;
	logic [1:0]  op_class;
	logic        op_flag;
	logic [1:0]  op_subclass;
	logic        event_present;
	logic [18:0] event_bits;

	modport source (output valid, output pc_address, output op_present, output op_class,
		output op_flag, output op_subclass, output event_present, output event_bits,
		input ready);
	modport sink (input valid, input pc_address, input op_present, input op_class,
		input op_flag, input op_subclass, input event_present, input event_bits,
		output ready);
endinterface

[sv/ptpp_front.sv]
module ptpp_front (
	input  logic               clk,
	input  logic               arst_n,
	ptpp_byte_if.sink          trace,
	input  logic               full,
	output logic               push,
	output ptpp_pkg::qentry_t  entry
);

	ptpp_pkg::phase_t phase_q, phase_d;
	ptpp_pkg::kind_t  kind_q, kind_d;
	logic             long_q, long_d;
	logic [7:0]       hfirst_q, hfirst_d;
	logic [3:0]       left_q, left_d;
	logic [2:0]       pos_q, pos_d;
	logic [7:0]       b;
	logic             acc;

	assign trace.ready = !full;
	assign acc = trace.valid && !full;
	assign b = trace.data_byte;

	always_comb begin
		phase_d = phase_q;
		kind_d = kind_q;
		long_d = long_q;
		hfirst_d = hfirst_q;
		left_d = left_q;
		pos_d = pos_q;
		push = 1'b0;
		entry.cmd = ptpp_pkg::CMD_DATA;
		entry.kind = kind_q;
		entry.data = b;
		entry.pos = pos_q;
		entry.last = (left_q == 4'd1);
		entry.is_pc = (hfirst_q[4:0] == 5'd0);
		entry.op_cls = hfirst_q[1:0];
		if (phase_q == ptpp_pkg::PH_DATA) begin
			push = acc;
			pos_d = pos_q + 3'd1;
			left_d = left_q - 4'd1;
			if (left_q == 4'd1) begin
				phase_d = ptpp_pkg::PH_HEADER;
			end
		end else begin
			long_d = 1'b0;
			pos_d = 3'd0;
			if (b == ptpp_pkg::HDR_PAD) begin
				long_d = 1'b0;
			end else if (b == ptpp_pkg::HDR_END) begin
				push = acc;
				entry.cmd = ptpp_pkg::CMD_END;
				kind_d = ptpp_pkg::K_UNKNOWN;
				hfirst_d = b;
			end else if (b == ptpp_pkg::HDR_TS) begin
				hfirst_d = b;
				kind_d = ptpp_pkg::K_TS;
				left_d = 4'd8;
				phase_d = ptpp_pkg::PH_DATA;
			end else if ((b & ptpp_pkg::MASK_MID) == ptpp_pkg::HDR_EVT ||
					(b & ptpp_pkg::MASK_MID) == ptpp_pkg::HDR_DSRC) begin
				hfirst_d = b;
				kind_d = ((b & ptpp_pkg::MASK_MID) == ptpp_pkg::HDR_EVT) ?
					ptpp_pkg::K_EVT : ptpp_pkg::K_DSRC;
				left_d = 4'd1 << b[5:4];
				phase_d = ptpp_pkg::PH_DATA;
			end else if ((b & ptpp_pkg::MASK_LO2) == ptpp_pkg::HDR_CTX) begin
				hfirst_d = b;
				kind_d = ptpp_pkg::K_CTX;
				left_d = 4'd4;
				phase_d = ptpp_pkg::PH_DATA;
			end else if ((b & ptpp_pkg::MASK_LO2) == ptpp_pkg::HDR_OP) begin
				hfirst_d = b;
				kind_d = ptpp_pkg::K_OP;
				left_d = 4'd1;
				phase_d = ptpp_pkg::PH_DATA;
			end else if ((b & ptpp_pkg::MASK_LO2) == ptpp_pkg::HDR_LONG) begin
				hfirst_d = b;
				long_d = 1'b1;
			end else if ((b & ptpp_pkg::MASK_LO3) == ptpp_pkg::HDR_ADDR) begin
				hfirst_d = long_q ? {3'b000, hfirst_q[1:0], b[2:0]} : {5'b00000, b[2:0]};
				kind_d = ptpp_pkg::K_ADDR;
				left_d = 4'd8;
				phase_d = ptpp_pkg::PH_DATA;
			end else if ((b & ptpp_pkg::MASK_LO3) == ptpp_pkg::HDR_CNT) begin
				hfirst_d = b;
				kind_d = ptpp_pkg::K_CNT;
				left_d = 4'd2;
				phase_d = ptpp_pkg::PH_DATA;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ptpp_pkg::PH_HEADER;
			kind_q <= ptpp_pkg::K_UNKNOWN;
			long_q <= 1'b0;
			hfirst_q <= 8'd0;
			left_q <= 4'd0;
			pos_q <= 3'd0;
		end else if (acc) begin
			phase_q <= phase_d;
			kind_q <= kind_d;
			long_q <= long_d;
			hfirst_q <= hfirst_d;
			left_q <= left_d;
			pos_q <= pos_d;
		end
	end

endmodule

[sv/ptpp_queue.sv]
module ptpp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ptpp_pkg::qentry_t  wr_entry,
	output logic               full,
	input  logic               pop,
	output logic               rd_valid,
	output ptpp_pkg::qentry_t  rd_entry
);

	ptpp_pkg::qentry_t              slot_q [ptpp_pkg::QUEUE_DEPTH];
	logic [ptpp_pkg::QUEUE_AW-1:0]  wr_ptr_q;
	logic [ptpp_pkg::QUEUE_AW-1:0]  rd_ptr_q;
	logic [ptpp_pkg::QUEUE_AW:0]    count_q;
	logic                           do_push;
	logic                           do_pop;

	assign full = (count_q == (ptpp_pkg::QUEUE_AW+1)'(ptpp_pkg::QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_entry = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[sv/ptpp_back.sv]
module ptpp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_valid,
	input  ptpp_pkg::qentry_t  rd_entry,
	output logic               pop,
	ptpp_rec_if.source         result
);

	logic [ptpp_pkg::PC_W-1:0]  accum_q;
	logic [ptpp_pkg::PC_W-1:0]  accum_next;
	logic [ptpp_pkg::PC_W-1:0]  rec_pc_q;
	logic                       rec_op_q;
	logic [1:0]                 rec_cls_q;
	logic [7:0]                 rec_pl_q;
	logic                       rec_evt_q;
	logic [ptpp_pkg::EVT_W-1:0] rec_evt_bits_q;
	logic                       out_valid_q;
	logic                       emit;
	logic                       finish;
	logic [1:0]                 cls;
	logic                       flag;
	logic [1:0]                 sub;

	assign finish = (rd_entry.cmd == ptpp_pkg::CMD_DATA) && rd_entry.last;
	assign emit = (rd_entry.cmd == ptpp_pkg::CMD_END) ||
		(finish && rd_entry.kind == ptpp_pkg::K_TS);
	assign pop = rd_valid && (!emit || !out_valid_q || result.ready);
	assign result.valid = out_valid_q;

	always_comb begin
		accum_next = ((rd_entry.pos == 3'd0) ? '0 : accum_q) |
			({{(ptpp_pkg::PC_W-8){1'b0}}, rd_entry.data} << {rd_entry.pos, 3'b000});
	end

	always_comb begin
		cls = rec_op_q ? rec_cls_q : 2'd0;
		flag = 1'b0;
		sub = ptpp_pkg::SUB_GP;
		if (rec_op_q && rec_cls_q == ptpp_pkg::OPC_LDST) begin
			flag = rec_pl_q[0];
			if (rec_pl_q[7:1] == 7'd0) begin
				sub = ptpp_pkg::SUB_GP;
			end else if (rec_pl_q[7:1] == ptpp_pkg::LDST_SIMD_CODE) begin
				sub = ptpp_pkg::SUB_SIMD;
			end else begin
				sub = ptpp_pkg::SUB_OTHER;
			end
		end else if (rec_op_q && rec_cls_q == ptpp_pkg::OPC_BR) begin
			flag = rec_pl_q[0];
			sub = {1'b0, rec_pl_q[1]};
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			result.pc_address <= rec_pc_q;
			result.op_present <= rec_op_q;
			result.op_class <= cls;
			result.op_flag <= flag;
			result.op_subclass <= sub;
			result.event_present <= rec_evt_q;
			result.event_bits <= rec_evt_q ? rec_evt_bits_q : '0;
		end
		if (pop && rd_entry.cmd == ptpp_pkg::CMD_DATA) begin
			accum_q <= accum_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rec_pc_q <= '0;
			rec_op_q <= 1'b0;
			rec_cls_q <= 2'd0;
			rec_pl_q <= 8'd0;
			rec_evt_q <= 1'b0;
			rec_evt_bits_q <= '0;
		end else begin
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop && emit) begin
				rec_pc_q <= '0;
				rec_op_q <= 1'b0;
				rec_cls_q <= 2'd0;
				rec_pl_q <= 8'd0;
				rec_evt_q <= 1'b0;
				rec_evt_bits_q <= '0;
			end else if (pop && finish) begin
				case (rd_entry.kind)
					ptpp_pkg::K_ADDR: begin
						if (rd_entry.is_pc) begin
							rec_pc_q <= accum_next;
						end
					end
					ptpp_pkg::K_OP: begin
						rec_op_q <= 1'b1;
						rec_cls_q <= rd_entry.op_cls;
						rec_pl_q <= accum_next[7:0];
					end
					ptpp_pkg::K_EVT: begin
						rec_evt_q <= 1'b1;
						rec_evt_bits_q <= accum_next[ptpp_pkg::EVT_W-1:0] & ptpp_pkg::EVT_MASK;
					end
					default: begin
						rec_evt_q <= rec_evt_q;
					end
				endcase
			end
		end
	end

endmodule

[sv/profiling_trace_packet_parser.sv]
// Profiling trace packet parser.
// trace: one raw byte of the profiling buffer per request (valid/ready).
// result: one request per closed record (END header or last TIMESTAMP
// byte) with the last PC address, operation class/subclass/flag and event
// bits of that record.
// A front stage classifies each byte as header or payload and tracks packet
// length; a four-entry queue hands payload and END commands to a back stage
// that assembles payloads, updates the record and fills the output register.
// Throughput: one byte per cycle, sustained while result is not stalled.
// A closing byte passes through a queue slot and then the output register
// before it shows on result.
// When result stalls, the back stage holds the closing command, the queue
// fills, and trace.ready drops once four commands are waiting.
// Reset (arst_n low) returns to header parsing with an empty record and an
// empty queue; no clearing pass is needed.
module profiling_trace_packet_parser (
	input  logic        clk,
	input  logic        arst_n,
	ptpp_byte_if.sink   trace,
	ptpp_rec_if.source  result
);

	logic               push;
	ptpp_pkg::qentry_t  wr_entry;
	logic               full;
	logic               pop;
	logic               rd_valid;
	ptpp_pkg::qentry_t  rd_entry;

	ptpp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.trace  (trace),
		.full   (full),
		.push   (push),
		.entry  (wr_entry)
	);

	ptpp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.full     (full),
		.pop      (pop),
		.rd_valid (rd_valid),
		.rd_entry (rd_entry)
	);

	ptpp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_valid (rd_valid),
		.rd_entry (rd_entry),
		.pop      (pop),
		.result   (result)
	);

endmodule
